### src/owtp_pkg.sv
// ----------------------------------------------------------------------------
// owtp_pkg
// Shared types, codes, microprogram and helper functions of the 1-Wire
// temperature poll sequencer.
// ----------------------------------------------------------------------------
package owtp_pkg;

	localparam int MAX_SENSORS_DEF = 8;
	localparam int PAD_LEN = 9;
	localparam logic [3:0] ROM_LEN = 4'd8;
	localparam logic [3:0] READ_LEN = 4'd9;

	// 1-Wire command bytes
	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT = 8'h44;
	localparam logic [7:0] CMD_MATCH_ROM = 8'h55;
	localparam logic [7:0] CMD_READ_PAD = 8'hBE;
	localparam logic [7:0] PAD_FILL = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h8C;

	// request function codes
	localparam logic [1:0] FN_POLL = 2'd0;
	localparam logic [1:0] FN_ROM = 2'd1;
	localparam logic [1:0] FN_PAD = 2'd2;

	// transport status codes
	localparam logic [1:0] BUS_OK = 2'd1;
	localparam logic [1:0] BUS_NODEV = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_TX = 2'd1;
	localparam logic [1:0] KIND_TEMP = 2'd2;

	// loop phases
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_CONV_BUS = 3'd1;
	localparam logic [2:0] PH_CONV_WAIT = 3'd2;
	localparam logic [2:0] PH_READ = 3'd3;
	localparam logic [2:0] PH_READ_BUS = 3'd4;
	localparam logic [2:0] PH_CHECK = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_RESOLUTION = 2'd0;
	localparam logic [1:0] CFG_DEVICE_COUNT = 2'd1;
	localparam logic [1:0] RES_RESET = 2'd3;

	// datapath operations
	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_WR_ROM = 4'd1;
	localparam logic [3:0] OP_WR_PAD = 4'd2;
	localparam logic [3:0] OP_CLR_CUR = 4'd3;
	localparam logic [3:0] OP_SET_PH1 = 4'd4;
	localparam logic [3:0] OP_BUS_ADV = 4'd5;
	localparam logic [3:0] OP_PH0 = 4'd6;
	localparam logic [3:0] OP_WAIT_CHK = 4'd7;
	localparam logic [3:0] OP_CLR_LC = 4'd8;
	localparam logic [3:0] OP_INC_LC = 4'd9;
	localparam logic [3:0] OP_PH4 = 4'd10;
	localparam logic [3:0] OP_CRC_INIT = 4'd11;
	localparam logic [3:0] OP_CRC_STEP = 4'd12;
	localparam logic [3:0] OP_CUR_ADV = 4'd13;

	// result sources
	localparam logic [2:0] EM_NONE = 3'd0;
	localparam logic [2:0] EM_STATUS = 3'd1;
	localparam logic [2:0] EM_CONST = 3'd2;
	localparam logic [2:0] EM_ROM = 3'd3;
	localparam logic [2:0] EM_TEMP = 3'd4;

	// jump conditions
	localparam logic [3:0] C_NEXT = 4'd0;
	localparam logic [3:0] C_ALWAYS = 4'd1;
	localparam logic [3:0] C_NOT_IN = 4'd2;
	localparam logic [3:0] C_DISPATCH = 4'd3;
	localparam logic [3:0] C_BUS_NODEV = 4'd4;
	localparam logic [3:0] C_BUS_NOTOK = 4'd5;
	localparam logic [3:0] C_LC_NE7 = 4'd6;
	localparam logic [3:0] C_LC_NE8 = 4'd7;
	localparam logic [3:0] C_CRC_BAD = 4'd8;

	// microprogram steps
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] S_IDLE = 5'd0;
	localparam logic [STEP_W-1:0] S_DEC = 5'd1;
	localparam logic [STEP_W-1:0] S_LDROM = 5'd2;
	localparam logic [STEP_W-1:0] S_LDPAD = 5'd3;
	localparam logic [STEP_W-1:0] S_NODEV = 5'd4;
	localparam logic [STEP_W-1:0] S_P0A = 5'd5;
	localparam logic [STEP_W-1:0] S_P0B = 5'd6;
	localparam logic [STEP_W-1:0] S_BUS = 5'd7;
	localparam logic [STEP_W-1:0] S_BUS2 = 5'd8;
	localparam logic [STEP_W-1:0] S_BUSOK = 5'd9;
	localparam logic [STEP_W-1:0] S_BUSFAIL = 5'd10;
	localparam logic [STEP_W-1:0] S_WAIT = 5'd11;
	localparam logic [STEP_W-1:0] S_P3 = 5'd12;
	localparam logic [STEP_W-1:0] S_ROMRD = 5'd13;
	localparam logic [STEP_W-1:0] S_ROMEM = 5'd14;
	localparam logic [STEP_W-1:0] S_BE = 5'd15;
	localparam logic [STEP_W-1:0] S_FF = 5'd16;
	localparam logic [STEP_W-1:0] S_FFL = 5'd17;
	localparam logic [STEP_W-1:0] S_P5 = 5'd18;
	localparam logic [STEP_W-1:0] S_CRC = 5'd19;
	localparam logic [STEP_W-1:0] S_CHK = 5'd20;
	localparam logic [STEP_W-1:0] S_TEMP = 5'd21;
	localparam logic [STEP_W-1:0] S_ADV = 5'd22;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] time_ms;
		logic [1:0]  bus_status;
		logic [7:0]  data_byte;
		logic [3:0]  byte_index;
		logic [2:0]  device_index;
	} owtp_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               status;
		logic [7:0]         tx_byte;
		logic [3:0]         read_count;
		logic               last;
		logic [2:0]         sensor;
		logic signed [15:0] temperature;
	} owtp_out_t;

	typedef struct packed {
		logic [3:0]        op;
		logic [2:0]        emit;
		logic [7:0]        tx;
		logic              rc9;
		logic              last;
		logic [3:0]        cond;
		logic [STEP_W-1:0] target;
	} owtp_uop_t;

	// sequencer -> datapath
	typedef struct packed {
		logic [3:0] op;
		logic [2:0] emit;
		logic [7:0] tx;
		logic       rc9;
		logic       last;
		logic       fire;
	} owtp_ctl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic [1:0] func;
		logic [1:0] bus;
		logic [2:0] phase;
		logic       dev_zero;
		logic       lc_ne7;
		logic       lc_ne8;
		logic       crc_ok;
		logic       out_free;
	} owtp_stat_t;

	function automatic logic [31:0] owtp_wait_ms(input logic [1:0] res);
		logic [31:0] w;
		case (res)
			2'd0: w = 32'd94;
			2'd1: w = 32'd188;
			2'd2: w = 32'd375;
			default: w = 32'd750;
		endcase
		return w;
	endfunction

	// one byte of the reflected CRC-8, LSB first
	function automatic logic [7:0] owtp_crc8_byte(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] c;
		logic [7:0] v;
		logic       mix;
		c = crc;
		v = din;
		for (int b = 0; b < 8; b++) begin
			mix = c[0] ^ v[0];
			c = c >> 1;
			if (mix) c = c ^ CRC_POLY;
			v = v >> 1;
		end
		return c;
	endfunction

	function automatic owtp_uop_t owtp_ucode(input logic [STEP_W-1:0] step);
		owtp_uop_t u;
		u.op = OP_NOP;
		u.emit = EM_NONE;
		u.tx = 8'h00;
		u.rc9 = 1'b0;
		u.last = 1'b0;
		u.cond = C_NEXT;
		u.target = S_IDLE;
		case (step)
			S_IDLE: begin
				u.cond = C_NOT_IN;
			end
			S_DEC: begin
				u.cond = C_DISPATCH;
			end
			S_LDROM: begin
				u.op = OP_WR_ROM;
				u.cond = C_ALWAYS;
			end
			S_LDPAD: begin
				u.op = OP_WR_PAD;
				u.cond = C_ALWAYS;
			end
			S_NODEV: begin
				u.emit = EM_STATUS;
				u.last = 1'b1;
				u.cond = C_ALWAYS;
			end
			S_P0A: begin
				u.op = OP_CLR_CUR;
				u.emit = EM_CONST;
				u.tx = CMD_SKIP_ROM;
			end
			S_P0B: begin
				u.op = OP_SET_PH1;
				u.emit = EM_CONST;
				u.tx = CMD_CONVERT;
				u.last = 1'b1;
				u.cond = C_ALWAYS;
			end
			S_BUS: begin
				u.cond = C_BUS_NODEV;
				u.target = S_BUSFAIL;
			end
			S_BUS2: begin
				u.cond = C_BUS_NOTOK;
			end
			S_BUSOK: begin
				u.op = OP_BUS_ADV;
				u.cond = C_ALWAYS;
			end
			S_BUSFAIL: begin
				u.op = OP_PH0;
				u.emit = EM_STATUS;
				u.last = 1'b1;
				u.cond = C_ALWAYS;
			end
			S_WAIT: begin
				u.op = OP_WAIT_CHK;
				u.cond = C_ALWAYS;
			end
			S_P3: begin
				u.op = OP_CLR_LC;
				u.emit = EM_CONST;
				u.tx = CMD_MATCH_ROM;
			end
			S_ROMRD: begin
				u.op = OP_INC_LC;
			end
			S_ROMEM: begin
				u.op = OP_INC_LC;
				u.emit = EM_ROM;
				u.cond = C_LC_NE8;
				u.target = S_ROMEM;
			end
			S_BE: begin
				u.op = OP_CLR_LC;
				u.emit = EM_CONST;
				u.tx = CMD_READ_PAD;
			end
			S_FF: begin
				u.op = OP_INC_LC;
				u.emit = EM_CONST;
				u.tx = PAD_FILL;
				u.cond = C_LC_NE7;
				u.target = S_FF;
			end
			S_FFL: begin
				u.op = OP_PH4;
				u.emit = EM_CONST;
				u.tx = PAD_FILL;
				u.rc9 = 1'b1;
				u.last = 1'b1;
				u.cond = C_ALWAYS;
			end
			S_P5: begin
				u.op = OP_CRC_INIT;
			end
			S_CRC: begin
				u.op = OP_CRC_STEP;
				u.cond = C_LC_NE7;
				u.target = S_CRC;
			end
			S_CHK: begin
				u.cond = C_CRC_BAD;
				u.target = S_ADV;
			end
			S_TEMP: begin
				u.emit = EM_TEMP;
				u.last = 1'b1;
			end
			S_ADV: begin
				u.op = OP_CUR_ADV;
				u.cond = C_ALWAYS;
			end
			default: begin
				u.cond = C_ALWAYS;
			end
		endcase
		return u;
	endfunction

endpackage

### src/owtp_stream_if.sv
// ----------------------------------------------------------------------------
// owtp_stream_if
// Valid/ready channel carrying one payload per handshake.
// ----------------------------------------------------------------------------
interface owtp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### src/onewire_temp_poll_sequencer.sv
// ----------------------------------------------------------------------------
// onewire_temp_poll_sequencer
// Polls up to MAX_SENSORS 1-Wire thermometers: start-convert frame, conversion
// wait, match-ROM read-scratchpad frames, CRC-8 check, temperature results.
//
//  port    dir  handshake        payload
//  item    in   valid/ready      owtp_in_t  (func, time_ms, bus_status, ...)
//  result  out  valid/ready      owtp_out_t (kind, status, tx_byte, ...)
//  cfg     in   cfg_we only      cfg_idx selects register, cfg_wdata value
//
// A microprogram step counter advances one step per cycle while no result is
// stalled. A read frame gives 19 results, and the CRC check, which may end in
// a temperature result, takes one scratchpad byte per cycle.
// item.ready is high only while the sequencer is idle.
// A stalled result holds the sequencer at its step; one result register.
// Reset clears the loop state and the config registers, not the stores.
// ----------------------------------------------------------------------------
module onewire_temp_poll_sequencer import owtp_pkg::*; #(
	parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	owtp_stream_if.sink   item,
	owtp_stream_if.source result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [3:0]  cfg_wdata
);
	logic [1:0] resolution_q;
	logic [3:0] device_count_q;
	logic       take;
	owtp_ctl_t  ctl;
	owtp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_q <= RES_RESET;
			device_count_q <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_RESOLUTION: resolution_q <= cfg_wdata[1:0];
				CFG_DEVICE_COUNT: device_count_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign take = item.valid && item.ready;

	owtp_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.item_ready(item.ready),
		.stat(stat),
		.ctl(ctl)
	);

	owtp_dp #(
		.MAX_SENSORS(MAX_SENSORS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.item_data(item.data),
		.resolution(resolution_q),
		.device_count(device_count_q),
		.ctl(ctl),
		.stat(stat),
		.rsp_valid(result.valid),
		.rsp_ready(result.ready),
		.rsp_data(result.data)
	);
endmodule

### src/owtp_ram.sv
// ----------------------------------------------------------------------------
// owtp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module owtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### src/owtp_seq.sv
// ----------------------------------------------------------------------------
// owtp_seq
// Microprogram sequencer: step counter, control-word table, jump logic.
// ----------------------------------------------------------------------------
module owtp_seq import owtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  owtp_stat_t stat,
	output owtp_ctl_t  ctl
);
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [STEP_W-1:0] disp;
	logic [STEP_W-1:0] step_inc;
	owtp_uop_t         uop;
	logic              acc;
	logic              go;
	logic              hit;

	assign uop = owtp_ucode(step_q);
	assign item_ready = (step_q == S_IDLE);
	assign acc = item_valid && item_ready;
	// a step that produces a result waits for room in the output register
	assign go = (uop.emit == EM_NONE) || stat.out_free;
	assign step_inc = step_q + 1'b1;

	always_comb begin
		disp = S_IDLE;
		case (stat.func)
			FN_ROM: disp = S_LDROM;
			FN_PAD: disp = S_LDPAD;
			FN_POLL: begin
				if (stat.dev_zero) begin
					disp = S_NODEV;
				end else begin
					case (stat.phase)
						PH_START: disp = S_P0A;
						PH_CONV_BUS: disp = S_BUS;
						PH_READ_BUS: disp = S_BUS;
						PH_CONV_WAIT: disp = S_WAIT;
						PH_READ: disp = S_P3;
						default: disp = S_P5;
					endcase
				end
			end
			default: disp = S_IDLE;
		endcase
	end

	always_comb begin
		case (uop.cond)
			C_ALWAYS: hit = 1'b1;
			C_NOT_IN: hit = !acc;
			C_BUS_NODEV: hit = (stat.bus == BUS_NODEV);
			C_BUS_NOTOK: hit = (stat.bus != BUS_OK);
			C_LC_NE7: hit = stat.lc_ne7;
			C_LC_NE8: hit = stat.lc_ne8;
			C_CRC_BAD: hit = !stat.crc_ok;
			default: hit = 1'b0;
		endcase
	end

	always_comb begin
		if (uop.cond == C_DISPATCH) step_d = disp;
		else if (hit) step_d = uop.target;
		else step_d = step_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (go) begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctl.op = uop.op;
		ctl.emit = uop.emit;
		ctl.tx = uop.tx;
		ctl.rc9 = uop.rc9;
		ctl.last = uop.last;
		ctl.fire = go;
	end

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> step_q == $past(step_q))
		else $error("step moved while its result was stalled");
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> step_q == S_DEC)
		else $error("accepted request not decoded next");
	a_jump_taken: assert property (@(posedge clk) disable iff (!arst_n)
		go && uop.cond == C_ALWAYS |=> step_q == $past(uop.target))
		else $error("unconditional jump missed");
	a_temp_crc: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == S_TEMP |-> stat.crc_ok)
		else $error("temperature step reached with bad CRC");
`endif
endmodule

### src/owtp_dp.sv
// ----------------------------------------------------------------------------
// owtp_dp
// Datapath: request register, loop state, ROM id store, scratchpad, CRC-8,
// elapsed-time check and the result register.
// ----------------------------------------------------------------------------
module owtp_dp import owtp_pkg::*; #(
	parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  owtp_in_t   item_data,
	input  logic [1:0] resolution,
	input  logic [3:0] device_count,
	input  owtp_ctl_t  ctl,
	output owtp_stat_t stat,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output owtp_out_t  rsp_data
);
	localparam int CUR_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int CNT_W = $clog2(MAX_SENSORS + 1);
	localparam int DEPTH = MAX_SENSORS * 8;
	localparam int ADDR_W = $clog2(DEPTH);

	owtp_in_t         item_q;
	logic [2:0]       phase_q;
	logic [CUR_W-1:0] cursor_q;
	logic [31:0]      start_q;
	logic [3:0]       lc_q;
	logic [7:0]       crc_q;
	logic [7:0]       pad_q [PAD_LEN];
	logic             out_valid_q;
	owtp_out_t        out_q;

	logic [31:0]       elapsed;
	logic              wait_done;
	logic [CNT_W-1:0]  count;
	logic              more;
	logic [7:0]        pad_rd;
	logic [7:0]        crc_next;
	logic              rom_we;
	logic              rom_re;
	logic [ADDR_W-1:0] rom_waddr;
	logic [ADDR_W-1:0] rom_raddr;
	logic [7:0]        rom_rdata;
	logic              emits;
	owtp_out_t         res_d;

	owtp_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_rom_ram (
		.clk(clk),
		.we(rom_we),
		.waddr(rom_waddr),
		.wdata(item_q.data_byte),
		.re(rom_re),
		.raddr(rom_raddr),
		.rdata(rom_rdata)
	);

	assign rom_we = ctl.fire && (ctl.op == OP_WR_ROM) && (item_q.byte_index < ROM_LEN)
		&& (32'(item_q.device_index) < MAX_SENSORS);
	assign rom_waddr = ADDR_W'({item_q.device_index, item_q.byte_index[2:0]});
	// read address runs one count ahead of the byte being sent
	assign rom_re = ctl.fire && (ctl.op == OP_INC_LC);
	assign rom_raddr = ADDR_W'({cursor_q, lc_q[2:0]});

	assign elapsed = item_q.time_ms - start_q;
	assign wait_done = elapsed > owtp_wait_ms(resolution);

	assign count = (32'(device_count) > MAX_SENSORS) ? CNT_W'(MAX_SENSORS)
		: CNT_W'(device_count);
	assign more = (32'(cursor_q) + 32'd1) < 32'(count);

	assign pad_rd = pad_q[lc_q[2:0]];
	assign crc_next = owtp_crc8_byte(crc_q, pad_rd);

	always_ff @(posedge clk) begin
		if (take) item_q <= item_data;
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && (ctl.op == OP_WR_PAD) && (item_q.byte_index < READ_LEN))
			pad_q[item_q.byte_index] <= item_q.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cursor_q <= '0;
			start_q <= '0;
			lc_q <= '0;
			crc_q <= '0;
		end else if (ctl.fire) begin
			case (ctl.op)
				OP_CLR_CUR: cursor_q <= '0;
				OP_SET_PH1: phase_q <= PH_CONV_BUS;
				OP_BUS_ADV: begin
					if (phase_q == PH_CONV_BUS) start_q <= item_q.time_ms;
					phase_q <= phase_q + 3'd1;
				end
				OP_PH0: phase_q <= PH_START;
				OP_WAIT_CHK: begin
					if (wait_done) phase_q <= PH_READ;
				end
				OP_CLR_LC: lc_q <= '0;
				OP_INC_LC: lc_q <= lc_q + 4'd1;
				OP_PH4: phase_q <= PH_READ_BUS;
				OP_CRC_INIT: begin
					lc_q <= '0;
					crc_q <= '0;
				end
				OP_CRC_STEP: begin
					crc_q <= crc_next;
					lc_q <= lc_q + 4'd1;
				end
				OP_CUR_ADV: begin
					if (more) begin
						cursor_q <= cursor_q + 1'b1;
						phase_q <= PH_READ;
					end else begin
						cursor_q <= '0;
						phase_q <= PH_START;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res_d = '0;
		res_d.last = ctl.last;
		case (ctl.emit)
			EM_STATUS: begin
				res_d.kind = KIND_STATUS;
				res_d.status = 1'b1;
			end
			EM_CONST: begin
				res_d.kind = KIND_TX;
				res_d.tx_byte = ctl.tx;
				res_d.read_count = ctl.rc9 ? READ_LEN : 4'd0;
			end
			EM_ROM: begin
				res_d.kind = KIND_TX;
				res_d.tx_byte = rom_rdata;
			end
			EM_TEMP: begin
				res_d.kind = KIND_TEMP;
				res_d.sensor = 3'(cursor_q);
				res_d.temperature = signed'({pad_q[1], pad_q[0]});
			end
			default: begin
			end
		endcase
	end

	assign emits = ctl.fire && (ctl.emit != EM_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emits) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emits) out_q <= res_d;
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;

	always_comb begin
		stat.func = item_q.func;
		stat.bus = item_q.bus_status;
		stat.phase = phase_q;
		stat.dev_zero = (device_count == 4'd0);
		stat.lc_ne7 = (lc_q != 4'd7);
		stat.lc_ne8 = (lc_q != 4'd8);
		stat.crc_ok = (crc_q == pad_q[PAD_LEN-1]);
		stat.out_free = !out_valid_q || rsp_ready;
	end
endmodule

### tb/owtp_poll_checker.sv
// ----------------------------------------------------------------------------
// owtp_poll_checker
// Watches the request, result and register-write ports of the 1-Wire
// temperature poll sequencer. Keeps its own copy of the poll loop state,
// builds the expected result bursts for every accepted request and compares
// each delivered result against the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module owtp_poll_checker import owtp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	owtp_stream_if     item,
	owtp_stream_if     result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [3:0] cfg_wdata,
	output int         fail_count,
	output int         pending,
	output int         checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = MAX_SENSORS_DEF;

	// shadow of the block's registers and loop state
	logic [1:0]  res_q;
	logic [3:0]  count_q;
	logic [2:0]  loop_phase;
	logic [2:0]  slot_cursor;
	logic [31:0] conv_start;
	logic [7:0]  rom_bytes [SLOTS*8];
	logic [7:0]  pad_bytes [PAD_LEN];

	owtp_out_t due_results [$];

	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic logic [31:0] conv_wait(input logic [1:0] res);
		case (res)
			2'd0: return 32'd94;
			2'd1: return 32'd188;
			2'd2: return 32'd375;
			default: return 32'd750;
		endcase
	endfunction

	// reflected CRC-8 over the first eight scratchpad bytes
	function automatic logic [7:0] pad_crc8();
		logic [7:0] c;
		logic [7:0] v;
		c = '0;
		for (int n = 0; n < 8; n++) begin
			v = pad_bytes[n];
			for (int k = 0; k < 8; k++) begin
				if (c[0] ^ v[0]) c = (c >> 1) ^ CRC_POLY;
				else c = c >> 1;
				v = v >> 1;
			end
		end
		return c;
	endfunction

	function automatic owtp_out_t make_result(input logic [1:0] kind, input logic status,
			input logic [7:0] tx, input logic [3:0] rc);
		owtp_out_t o;
		o = '0;
		o.kind = kind;
		o.status = status;
		o.tx_byte = tx;
		o.read_count = rc;
		return o;
	endfunction

	task automatic advance_poll_loop(input owtp_in_t r);
		owtp_out_t   burst [$];
		owtp_out_t   o;
		int          active;
		logic [31:0] elapsed;
		case (r.func)
			FN_ROM: begin
				// device_index is 3 bits, so every slot is in range
				if (r.byte_index < ROM_LEN)
					rom_bytes[int'(r.device_index) * 8 + int'(r.byte_index)] = r.data_byte;
			end
			FN_PAD: begin
				if (r.byte_index < READ_LEN)
					pad_bytes[r.byte_index] = r.data_byte;
			end
			FN_POLL: begin
				active = (count_q > SLOTS) ? SLOTS : int'(count_q);
				if (active == 0) begin
					burst.push_back(make_result(KIND_STATUS, 1'b1, 8'h00, 4'd0));
				end else begin
					case (loop_phase)
						PH_START: begin
							slot_cursor = '0;
							burst.push_back(make_result(KIND_TX, 1'b0, CMD_SKIP_ROM, 4'd0));
							burst.push_back(make_result(KIND_TX, 1'b0, CMD_CONVERT, 4'd0));
							loop_phase = PH_CONV_BUS;
						end
						PH_CONV_BUS, PH_READ_BUS: begin
							if (r.bus_status == BUS_NODEV) begin
								loop_phase = PH_START;
								burst.push_back(make_result(KIND_STATUS, 1'b1, 8'h00, 4'd0));
							end else if (r.bus_status == BUS_OK) begin
								if (loop_phase == PH_CONV_BUS) conv_start = r.time_ms;
								loop_phase = loop_phase + 3'd1;
							end
						end
						PH_CONV_WAIT: begin
							elapsed = r.time_ms - conv_start;
							if (elapsed > conv_wait(res_q)) loop_phase = PH_READ;
						end
						PH_READ: begin
							burst.push_back(make_result(KIND_TX, 1'b0, CMD_MATCH_ROM, 4'd0));
							for (int i = 0; i < 8; i++)
								burst.push_back(make_result(KIND_TX, 1'b0,
									rom_bytes[int'(slot_cursor) * 8 + i], 4'd0));
							burst.push_back(make_result(KIND_TX, 1'b0, CMD_READ_PAD, 4'd0));
							for (int i = 0; i < PAD_LEN; i++)
								burst.push_back(make_result(KIND_TX, 1'b0, PAD_FILL,
									(i == PAD_LEN - 1) ? READ_LEN : 4'd0));
							loop_phase = PH_READ_BUS;
						end
						default: begin
							if (pad_crc8() == pad_bytes[8]) begin
								o = make_result(KIND_TEMP, 1'b0, 8'h00, 4'd0);
								o.sensor = slot_cursor;
								o.temperature = {pad_bytes[1], pad_bytes[0]};
								burst.push_back(o);
							end
							// a shrunk count ends the loop here as well
							if (int'(slot_cursor) < active - 1) begin
								slot_cursor = slot_cursor + 3'd1;
								loop_phase = PH_READ;
							end else begin
								slot_cursor = '0;
								loop_phase = PH_START;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
		if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i]) due_results.push_back(burst[i]);
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
				checked, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		owtp_out_t want;
		if (!arst_n) begin
			res_q = RES_RESET;
			count_q = '0;
			loop_phase = PH_START;
			slot_cursor = '0;
			conv_start = '0;
			due_results.delete();
			fail_count = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_RESOLUTION) res_q = cfg_wdata[1:0];
				else if (cfg_idx == CFG_DEVICE_COUNT) count_q = cfg_wdata;
			end
			if (item.valid && item.ready) advance_poll_loop(item.data);
			if (result.valid && result.ready) begin
				checked++;
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with nothing due: %p",
						checked, result.data));
				end else begin
					want = due_results.pop_front();
					compare_field("kind", 16'(result.data.kind), 16'(want.kind));
					compare_field("status", 16'(result.data.status), 16'(want.status));
					compare_field("tx_byte", 16'(result.data.tx_byte), 16'(want.tx_byte));
					compare_field("read_count", 16'(result.data.read_count),
						16'(want.read_count));
					compare_field("last", 16'(result.data.last), 16'(want.last));
					compare_field("sensor", 16'(result.data.sensor), 16'(want.sensor));
					compare_field("temperature", result.data.temperature, want.temperature);
				end
			end
			pending <= due_results.size();
		end
	end

endmodule

### tb/onewire_temp_poll_sequencer_tb.sv
// ----------------------------------------------------------------------------
// onewire_temp_poll_sequencer_tb
// Drives the poll sequencer through its conversion/read loop: ROM and
// scratchpad loads, bus busy/ok/no-device replies, conversion-wait boundaries
// with time wraparound, good and corrupted CRCs and count changes mid-loop,
// under four sender/receiver idle mixes. Checking is done by owtp_poll_checker.
// ----------------------------------------------------------------------------
module onewire_temp_poll_sequencer_tb import owtp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int IN_W = $bits(owtp_in_t);

	localparam logic [1:0] FN_RSVD = 2'd3;
	localparam logic [1:0] BUS_BUSY = 2'd0;
	localparam logic [1:0] BUS_RSVD = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [3:0] cfg_wdata;

	int fail_count;
	int pending;
	int checked;
	int gap_pct = 0;
	int stall_pct = 0;
	int sent_count = 0;
	int ignored_count = 0;
	int cycle_count = 0;

	// stimulus-side view of the loop, used only to shape well-formed sequences
	logic [2:0]  loop_ph = PH_START;
	int          loop_cur = 0;
	logic [31:0] loop_start = '0;
	logic [1:0]  cfg_res = RES_RESET;
	logic [3:0]  cfg_cnt = '0;

	owtp_stream_if #(.payload_t(owtp_in_t))  item ();
	owtp_stream_if #(.payload_t(owtp_out_t)) result ();

	onewire_temp_poll_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	owtp_poll_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) result.ready <= 1'b0;
		else result.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due", cycle_count, pending);
			$display("== FAIL ==");
			$finish;
		end
	end

	// valid is left high so back-to-back requests need no extra edge
	task automatic push_request(input owtp_in_t r);
		while ($urandom_range(99) < gap_pct) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1;
		item.data <= r;
		do @(posedge clk); while (!item.ready);
		sent_count++;
		if (r.func == FN_RSVD || (r.func == FN_ROM && r.byte_index >= ROM_LEN) ||
				(r.func == FN_PAD && r.byte_index >= READ_LEN))
			ignored_count++;
	endtask

	task automatic poll(input logic [31:0] t, input logic [1:0] bus);
		owtp_in_t r;
		r = IN_W'({$urandom, $urandom});
		r.func = FN_POLL;
		r.time_ms = t;
		r.bus_status = bus;
		push_request(r);
	endtask

	task automatic load_byte(input logic [1:0] fn, input logic [3:0] idx,
			input logic [2:0] slot, input logic [7:0] data);
		owtp_in_t r;
		r = IN_W'({$urandom, $urandom});
		r.func = fn;
		r.byte_index = idx;
		r.device_index = slot;
		r.data_byte = data;
		push_request(r);
	endtask

	// nine scratchpad bytes; a bad CRC gets one bit flipped
	task automatic load_pad(input bit good, input bit pin_temp, input logic [15:0] temp);
		logic [7:0] b [PAD_LEN];
		logic [7:0] c;
		for (int k = 0; k < 8; k++) b[k] = 8'($urandom);
		if (pin_temp) {b[1], b[0]} = temp;
		c = '0;
		for (int k = 0; k < 8; k++) c = owtp_crc8_byte(c, b[k]);
		b[8] = good ? c : c ^ (8'h01 << $urandom_range(7));
		for (int k = 0; k < PAD_LEN; k++) load_byte(FN_PAD, 4'(k), 3'($urandom), b[k]);
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] res, input logic [3:0] cnt);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= CFG_RESOLUTION;
		cfg_wdata <= {2'b00, res};
		@(posedge clk);
		cfg_idx <= CFG_DEVICE_COUNT;
		cfg_wdata <= cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_res = res;
		cfg_cnt = cnt;
	endtask

	task automatic noise_request();
		owtp_in_t r;
		r = IN_W'({$urandom, $urandom});
		case ($urandom_range(4))
			0: r.func = FN_RSVD;
			1: begin
				r.func = FN_ROM;
				r.byte_index = 4'($urandom_range(15, 8));
			end
			2: begin
				r.func = FN_PAD;
				r.byte_index = 4'($urandom_range(15, 9));
			end
			3: begin
				r.func = FN_ROM;
				r.byte_index = 4'($urandom_range(7));
			end
			default: begin
				r.func = FN_PAD;
				r.byte_index = 4'($urandom_range(8));
			end
		endcase
		push_request(r);
	endtask

	// one well-formed step of the poll loop, with occasional busy/no-device replies
	task automatic loop_step();
		int          lim;
		int          pick;
		logic [31:0] t;
		logic [31:0] w;
		logic [31:0] delta;
		logic [1:0]  bus;
		lim = (cfg_cnt > 4'd8) ? 8 : int'(cfg_cnt);
		pick = $urandom_range(99);
		if (lim == 0) begin
			poll($urandom, 2'($urandom));
		end else begin
			case (loop_ph)
				PH_START: begin
					poll($urandom, 2'($urandom));
					loop_cur = 0;
					loop_ph = PH_CONV_BUS;
				end
				PH_CONV_BUS, PH_READ_BUS: begin
					t = $urandom;
					if (pick < 72) bus = BUS_OK;
					else if (pick < 82) bus = BUS_NODEV;
					else if (pick < 91) bus = BUS_BUSY;
					else bus = BUS_RSVD;
					poll(t, bus);
					if (bus == BUS_NODEV) begin
						loop_ph = PH_START;
					end else if (bus == BUS_OK) begin
						if (loop_ph == PH_CONV_BUS) loop_start = t;
						loop_ph = loop_ph + 3'd1;
					end
				end
				PH_CONV_WAIT: begin
					w = owtp_wait_ms(cfg_res);
					if (pick < 15) delta = w;
					else if (pick < 30) delta = $urandom_range(w);
					else if (pick < 40) delta = $urandom;
					else delta = w + 32'd1 + $urandom_range(40);
					poll(loop_start + delta, 2'($urandom));
					if (delta > w) loop_ph = PH_READ;
				end
				PH_READ: begin
					poll($urandom, 2'($urandom));
					loop_ph = PH_READ_BUS;
				end
				PH_CHECK: begin
					if (pick < 85)
						load_pad($urandom_range(99) < 80, $urandom_range(99) < 20,
							($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000);
					poll($urandom, 2'($urandom));
					if (loop_cur < lim - 1) begin
						loop_cur++;
						loop_ph = PH_READ;
					end else begin
						loop_cur = 0;
						loop_ph = PH_START;
					end
				end
				default: poll($urandom, 2'($urandom));
			endcase
		end
	endtask

	task automatic run_random_phase(input logic [1:0] res, input logic [3:0] cnt,
			input int gap, input int stall, input int quota);
		int base;
		set_config(res, cnt);
		gap_pct = gap;
		stall_pct = stall;
		base = sent_count - ignored_count;
		while (sent_count - ignored_count - base < quota) begin
			if ($urandom_range(99) < 15) noise_request();
			else loop_step();
		end
	endtask

	initial begin
		item.valid <= 1'b0;
		item.data <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_RESOLUTION;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every ROM slot and scratchpad byte is written before anything reads it
		for (int s = 0; s < 8; s++)
			for (int b = 0; b < 8; b++)
				load_byte(FN_ROM, 4'(b), 3'(s), 8'($urandom));
		load_pad(1'b1, 1'b1, 16'h8000);

		// no device configured yet
		poll($urandom, BUS_OK);

		set_config(2'd0, 4'd1);
		poll($urandom, BUS_OK);
		poll($urandom, BUS_BUSY);
		poll($urandom, BUS_RSVD);
		poll(32'hFFFF_FFF0, BUS_OK);
		poll(32'hFFFF_FFF0 + 32'd94, BUS_BUSY);      // exactly the wait: stays
		poll(32'hFFFF_FFF0 + 32'd95, BUS_BUSY);      // one past, across the wrap
		poll($urandom, BUS_OK);                       // read frame
		poll($urandom, BUS_NODEV);                    // sensor vanished: restart
		poll($urandom, BUS_OK);
		poll(32'h0000_0000, BUS_OK);
		poll(32'hFFFF_FFFF, BUS_OK);
		poll($urandom, BUS_OK);
		poll($urandom, BUS_OK);
		poll($urandom, BUS_NODEV);                    // CRC good, most negative reading
		load_byte(FN_RSVD, 4'd0, 3'd0, 8'hFF);
		load_byte(FN_ROM, 4'd15, 3'd7, 8'h00);
		load_byte(FN_PAD, 4'd15, 3'd0, 8'hFF);
		loop_ph = PH_START;
		loop_cur = 0;

		run_random_phase(2'd3, 4'd8, 0, 0, 20);
		run_random_phase(2'd1, 4'd15, 77, 0, 20);
		run_random_phase(2'd2, 4'd2, 0, 77, 20);
		run_random_phase(2'd0, 4'd5, 34, 34, 20);
		run_random_phase(2'd3, 4'd0, 34, 34, 4);
		drain();

		$display("Run covered %0d requests (%0d ignored) and %0d checked results",
			sent_count, ignored_count, checked);
		$display("Resolutions 0-3, device counts 0-15, four sender/receiver idle mixes");
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results still due", fail_count, pending);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### files.f
src/owtp_pkg.sv
src/owtp_stream_if.sv
src/owtp_ram.sv
src/owtp_seq.sv
src/owtp_dp.sv
src/onewire_temp_poll_sequencer.sv
tb/owtp_poll_checker.sv
tb/onewire_temp_poll_sequencer_tb.sv
